// ----- hdl/mts_pkg.sv -----
`default_nettype none

package mts_pkg;

    // Command codes carried in the opcode field.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Field widths of one request and one result.
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 11;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int RES_W       = STATUS_W + VALUE_W + DEPTH_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One result; status sits in the lowest bits when packed.
    typedef struct packed {
        logic [DEPTH_W-1:0]        depth_now;
        logic signed [VALUE_W-1:0] min_value;
        status_t                   status;
    } mts_result_t;

endpackage

`default_nettype wire

// ----- hdl/mts_core.sv -----
`default_nettype none

module mts_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [OPCODE_W-1:0]       opcode,
    input  logic signed [VALUE_W-1:0] push_value,
    output mts_result_t               result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Running minimum of every entry; entries above the fill count are stale.
    logic signed [VALUE_W-1:0] min_mem [STACK_DEPTH];

    logic [CW-1:0]             fill_reg, fill_next;
    logic                      below_in_mem_reg, below_in_mem_next;
    logic signed [VALUE_W-1:0] top_reg, top_next;
    logic signed [VALUE_W-1:0] below_reg, below_next;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] below_now;
    logic signed [VALUE_W-1:0] push_min;
    logic                      wr_en, rd_en;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic                      is_empty, is_full;
    status_t                   status;

    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg >= CW'(STACK_DEPTH));
    // After a pop the entry under the top arrives from the memory read register.
    assign below_now = below_in_mem_reg ? rd_data_reg : below_reg;
    assign push_min  = (!is_empty && (top_reg < push_value)) ? top_reg : push_value;
    assign wr_addr   = fill_reg[AW-1:0];
    assign rd_addr   = AW'(fill_reg - CW'(3));

    // Command decode and next state of the cached top two entries.
    always_comb
    begin
        fill_next         = fill_reg;
        top_next          = top_reg;
        below_next        = below_reg;
        below_in_mem_next = below_in_mem_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        status            = ST_DONE;
        case (opcode)
            OP_PUSH:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr_en             = accept;
                    top_next          = push_min;
                    below_next        = top_reg;
                    below_in_mem_next = 1'b0;
                    fill_next         = fill_reg + CW'(1);
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd_en             = accept;
                    top_next          = below_now;
                    below_in_mem_next = 1'b1;
                    fill_next         = fill_reg - CW'(1);
                end
            end
            default:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
            end
        endcase
    end

    // Result after the command.
    always_comb
    begin
        result.status    = status;
        result.min_value = (fill_next == '0) ? '0 : top_next;
        result.depth_now = DEPTH_W'(fill_next);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            below_in_mem_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg         <= fill_next;
            below_in_mem_reg <= below_in_mem_next;
        end
    end

    // Cached top and next-to-top running minimums.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg   <= top_next;
            below_reg <= below_next;
        end
    end

    // Running-minimum memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            min_mem[wr_addr] <= push_min;
        end
        if (rd_en)
        begin
            rd_data_reg <= min_mem[rd_addr];
        end
    end

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(STACK_DEPTH))
        else $error("fill count above capacity");

    // A pop on a non-empty stack removes exactly one entry.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_POP && fill_reg != '0 |=> fill_reg == $past(fill_reg) - CW'(1))
        else $error("pop did not remove one entry");

    // A push on a full stack is dropped and leaves the count alone.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_PUSH && is_full |-> status == ST_FULL ##1 $stable(fill_reg))
        else $error("push on full stack changed the count");

    // A taken push leaves a minimum no larger than the pushed value.
    a_push_min: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_PUSH && !is_full |-> result.min_value <= push_value)
        else $error("minimum above pushed value");

endmodule

`default_nettype wire

// ----- hdl/mts_out_buf.sv -----
`default_nettype none

module mts_out_buf
    import mts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mts_result_t in_res,
    output logic        out_valid,
    input  logic        out_ready,
    output mts_result_t out_res
);

    logic        out_valid_reg, skid_valid_reg;
    mts_result_t out_res_reg, skid_res_reg;

    // New results are taken whenever the skid stage is free.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Valid flags of the result register and the skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_ready && out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // Result payloads.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_res_reg <= in_res;
            end
            else
            begin
                skid_res_reg <= in_res;
            end
        end
        else if (out_ready && out_valid_reg)
        begin
            out_res_reg <= skid_res_reg;
        end
    end

    // The skid stage only fills behind a waiting result.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result with the output empty");

    // A result held in the skid stage moves forward when the output drains.
    a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid result not forwarded");

endmodule

`default_nettype wire

// ----- hdl/min_tracking_stack.sv -----
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: opcode, push_value
// m_axis    out        m_tvalid/m_tready  m_tdata: status, min_value, depth_now
//
// Each request is executed in the cycle it is accepted; its result is registered in
// the output register, or in the skid stage while the output stalls, so one request
// per cycle is sustained while m_tready holds high. The cached top and next-to-top
// minimums plus one registered memory read per pop let each command execute on acceptance.
// Reset empties the stack at once; memory contents need no clearing pass.
// A stalled output holds one result and one more in a skid stage, then
// s_tready drops until the output drains.
`default_nettype none

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [1:0] opcode, [33:2] push_value, rest zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] status, [33:2] min_value,
                                              // [44:34] depth_now, rest zero
);

    logic        accept;
    mts_result_t core_res;
    mts_result_t out_res;

    assign accept = s_tvalid && s_tready;

    // Stack state and command execution.
    mts_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (s_tdata[OPCODE_W-1:0]),
        .push_value (s_tdata[OPCODE_W +: VALUE_W]),
        .result     (core_res)
    );

    // Result register with skid stage.
    mts_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire

// ----- bench/tb_min_tracking_stack.sv -----
module tb_min_tracking_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int STACK_CAP = 1024;
    localparam int STALL_PCT = 21;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int CALM_FIRST = 500;
    localparam int CALM_LAST = 800;

    // The spare opcode is not named by the package; the block treats it as a query.
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  push_value;
        bit                  typed;
        mts_result_t         result;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow of the stack: running minimum per entry and the fill level.
    logic signed [VALUE_W-1:0] shadow_min [STACK_CAP];
    int                        shadow_fill = 0;

    mts_result_t   pending_results[$];
    directed_row_t directed_rows[$];
    bit            calm = 1'b0;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            request_count = 0;
    int            result_count = 0;
    int            push_count = 0;
    int            pop_count = 0;
    int            query_count = 0;
    int            full_hits = 0;
    int            empty_hits = 0;
    int            peak_fill = 0;

    min_tracking_stack #(
        .STACK_DEPTH(STACK_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command to the shadow stack and return the result it must give.
    function automatic mts_result_t apply_command(input logic [OPCODE_W-1:0] opcode,
                                                  input logic signed [VALUE_W-1:0] value);
        mts_result_t res;
        logic signed [VALUE_W-1:0] low;
        res.status = ST_DONE;
        case (opcode)
            OP_PUSH:
            begin
                push_count++;
                if (shadow_fill >= STACK_CAP)
                begin
                    res.status = ST_FULL;
                    full_hits++;
                end
                else
                begin
                    low = value;
                    if (shadow_fill > 0 && shadow_min[shadow_fill-1] < low)
                        low = shadow_min[shadow_fill-1];
                    shadow_min[shadow_fill] = low;
                    shadow_fill++;
                    if (shadow_fill > peak_fill)
                        peak_fill = shadow_fill;
                end
            end
            OP_POP:
            begin
                pop_count++;
                if (shadow_fill == 0)
                begin
                    res.status = ST_EMPTY;
                    empty_hits++;
                end
                else
                    shadow_fill--;
            end
            default:
            begin
                query_count++;
                if (shadow_fill == 0)
                begin
                    res.status = ST_EMPTY;
                    empty_hits++;
                end
            end
        endcase
        res.min_value = (shadow_fill == 0) ? '0 : shadow_min[shadow_fill-1];
        res.depth_now = DEPTH_W'(shadow_fill);
        return res;
    endfunction

    // Mostly small values so the minimum moves often, with extremes and full-range values.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return VALUE_W'($urandom_range(200)) - 32'd100;
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return OP_PUSH;
        if (roll < push_pct + pop_pct)
            return OP_POP;
        return ($urandom_range(3) == 0) ? OP_SPARE : OP_QUERY;
    endfunction

    task automatic add_row(input logic [OPCODE_W-1:0] opcode, input logic [VALUE_W-1:0] value,
                           input bit typed, input status_t status,
                           input logic [VALUE_W-1:0] min_value, input int depth);
        directed_row_t row;
        row.opcode = opcode;
        row.push_value = value;
        row.typed = typed;
        row.result.status = status;
        row.result.min_value = min_value;
        row.result.depth_now = DEPTH_W'(depth);
        directed_rows.push_back(row);
    endtask

    // Offer one request, wait for it to be taken, and record its expected result.
    task automatic send_request(input logic [OPCODE_W-1:0] opcode,
                                input logic [VALUE_W-1:0] value,
                                input bit typed, input mts_result_t typed_result);
        mts_result_t predicted;
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= IN_TDATA_W'({$urandom, $urandom});
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - OPCODE_W - VALUE_W){1'b0}}, value, opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_command(opcode, value);
        pending_results.push_back(typed ? typed_result : predicted);
        request_count++;
    endtask

    // Hold the input off until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Output side stalls at random except during the calm window.
    always @(posedge clk)
        m_tready <= (calm || $urandom_range(99) >= STALL_PCT);

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        mts_result_t got;
        mts_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mts_result_t'(m_tdata[RES_W-1:0]);
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got status %0d min %0d depth %0d",
                         $time, got.status, got.min_value, got.depth_now);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.min_value !== want.min_value)
                begin
                    $display("%0t: min_value mismatch: expected %0d, got %0d",
                             $time, want.min_value, got.min_value);
                    mismatch_count++;
                end
                if (got.depth_now !== want.depth_now)
                begin
                    $display("%0t: depth_now mismatch: expected %0d, got %0d",
                             $time, want.depth_now, got.depth_now);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        mts_result_t blank;
        int n;
        blank = '0;

        // Empty-stack commands, extremes, equal values, spare opcode, drain past empty.
        add_row(OP_QUERY, 32'd0,         1, ST_EMPTY, 32'd0, 0);
        add_row(OP_POP,   32'd0,         1, ST_EMPTY, 32'd0, 0);
        add_row(OP_SPARE, 32'd0,         1, ST_EMPTY, 32'd0, 0);
        add_row(OP_PUSH,  32'h7FFF_FFFF, 1, ST_DONE,  32'h7FFF_FFFF, 1);
        add_row(OP_PUSH,  32'h8000_0000, 1, ST_DONE,  32'h8000_0000, 2);
        add_row(OP_PUSH,  32'd0,         1, ST_DONE,  32'h8000_0000, 3);
        add_row(OP_QUERY, 32'd0,         1, ST_DONE,  32'h8000_0000, 3);
        add_row(OP_POP,   32'd0,         1, ST_DONE,  32'h8000_0000, 2);
        add_row(OP_POP,   32'd0,         1, ST_DONE,  32'h7FFF_FFFF, 1);
        add_row(OP_PUSH,  32'hFFFF_FFFF, 0, ST_DONE,  32'd0, 0);
        add_row(OP_PUSH,  32'hFFFF_FFFF, 0, ST_DONE,  32'd0, 0);
        add_row(OP_PUSH,  32'd100,       0, ST_DONE,  32'd0, 0);
        add_row(OP_SPARE, 32'hFFFF_FFFF, 0, ST_DONE,  32'd0, 0);
        add_row(OP_PUSH,  32'hFFFF_FFFE, 0, ST_DONE,  32'd0, 0);
        add_row(OP_POP,   32'd0,         0, ST_DONE,  32'd0, 0);
        add_row(OP_POP,   32'd0,         0, ST_DONE,  32'd0, 0);
        add_row(OP_QUERY, 32'd0,         0, ST_DONE,  32'd0, 0);
        add_row(OP_PUSH,  32'h5555_5555, 0, ST_DONE,  32'd0, 0);
        add_row(OP_PUSH,  32'hAAAA_AAAA, 0, ST_DONE,  32'd0, 0);
        for (n = 0; n < 4; n++)
            add_row(OP_POP, 32'd0,       0, ST_DONE,  32'd0, 0);
        add_row(OP_POP,   32'd0,         1, ST_DONE,  32'd0, 0);
        add_row(OP_POP,   32'd0,         1, ST_EMPTY, 32'd0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].opcode, directed_rows[i].push_value,
                         directed_rows[i].typed, directed_rows[i].result);
        drain_results();

        // Balanced traffic around an empty or shallow stack.
        for (n = 0; n < 300; n++)
            send_request(pick_opcode(40, 40), pick_value(), 0, blank);
        drain_results();

        // Push-heavy traffic until the stack is full, with a calm window inside.
        n = 0;
        while (shadow_fill < STACK_CAP)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            send_request(pick_opcode(92, 5), pick_value(), 0, blank);
            n++;
        end
        calm = 1'b0;

        // Mixed traffic at the top, so full-stack pushes recur.
        for (n = 0; n < 150; n++)
            send_request(pick_opcode(55, 35), pick_value(), 0, blank);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d push, %0d pop, %0d query), checked %0d results.",
                 request_count, push_count, pop_count, query_count, result_count);
        $display("Peak depth %0d, %0d pushes refused on a full stack, %0d commands on empty.",
                 peak_fill, full_hits, empty_hits);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
